### design/rtu_pkg.sv
// Shared types and constants for the RTU frame receiver.
// No dependencies; imported by rtu_crc16 and rtu_frame_receiver.
package rtu_pkg;

  localparam int unsigned MAX_FRAME_DEF = 256;
  localparam int unsigned MIN_FRAME     = 8;

  localparam logic [7:0]  SILENCE_RESET = 8'd149;
  localparam logic [7:0]  STATION_RESET = 8'd1;
  localparam logic [7:0]  SILENCE_SAT   = 8'hFF;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration register indexes
  localparam logic CFG_SILENCE_TICKS = 1'b0;
  localparam logic CFG_STATION_ADDR  = 1'b1;

  typedef enum logic [1:0] {
    LINK_SYNC = 2'd0,
    LINK_WAIT = 2'd1,
    LINK_RX   = 2'd2
  } link_state_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_SHORT    = 3'd1,
    CAUSE_ADDRESS  = 3'd2,
    CAUSE_CRC      = 3'd3,
    CAUSE_OVERFLOW = 3'd4
  } cause_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [8:0]  frame_length;
    cause_t      reject_cause;
  } result_t;

endpackage

### design/rtu_frame_receiver.sv
// RTU frame receiver top level: silence framing, CRC check, output skid buffer.
// Depends on rtu_pkg and rtu_crc16.
//
// Usage:
//   Input beats are either a received byte (in_op = 0, with in_rx_byte and
//   in_framing_error) or one timer tick (in_op = 1). Frames are delimited by
//   line silence of cfg silence_ticks ticks. Each stored frame byte leaves as
//   a data beat with its index; at frame end one accept or reject beat leaves
//   with the frame length and the reject cause. An input beat yields zero or
//   one output beat.
//   Output beats are registered in out_r, or in the skid register while the
//   output is stalled. Throughput: one input beat per cycle while in_stall
//   is low; the frame state and the byte-wide CRC update are combinational.
//   Stall: the output register is backed by a one-beat skid register, so a
//   stalled receiver costs nothing until both are full; in_stall is then
//   raised (it is a registered signal) until the skid beat drains.
//   Reset: link goes to sync (waits for a full silence before listening),
//   silence_ticks = 149, station_address = 1, output side empty.
//   Configuration writes through cfg_we/cfg_index/cfg_data take effect on the
//   next edge and are expected only while the block is idle.
module rtu_frame_receiver #(
  parameter int unsigned MAX_FRAME = rtu_pkg::MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  input  logic       in_framing_error,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_byte_index,
  output logic [8:0] out_frame_length,
  output logic [2:0] out_reject_cause
);
  import rtu_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME);

  // configuration
  logic [7:0] silence_ticks_r;
  logic [7:0] station_addr_r;

  // link state
  link_state_t     link_r, link_nxt;
  logic [7:0]      sc_r, sc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic            addr_ok_r, addr_ok_nxt;
  logic            ovf_r, ovf_nxt;

  // output side
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;

  result_t res;
  logic    res_valid;
  logic    accept;
  logic    is_tick;
  logic [7:0] sc_inc;
  logic    tick_hit;      // silence reached on this tick
  logic    late;          // silence already reached before this byte
  logic    byte_drop;     // framing error or late byte in a frame
  logic [15:0] crc_upd;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid & ~in_stall;
  assign is_tick  = in_op;
  assign sc_inc   = (sc_r == SILENCE_SAT) ? sc_r : sc_r + 8'd1;
  assign tick_hit = (sc_inc >= silence_ticks_r);
  assign late     = (sc_r >= silence_ticks_r);
  assign byte_drop = in_framing_error | ((link_r == LINK_RX) & late);

  rtu_crc16 u_crc (
    .crc_in  (crc_r),
    .data    (in_rx_byte),
    .crc_out (crc_upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_ticks_r <= SILENCE_RESET;
      station_addr_r  <= STATION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SILENCE_TICKS: silence_ticks_r <= cfg_data;
        CFG_STATION_ADDR:  station_addr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // next link state
  always_comb begin
    link_nxt = link_r;
    if (accept) begin
      if (is_tick) begin
        if (link_r != LINK_WAIT && tick_hit) begin
          link_nxt = LINK_WAIT;
        end
      end else begin
        unique case (link_r)
          LINK_SYNC: link_nxt = LINK_SYNC;
          LINK_WAIT,
          LINK_RX:   link_nxt = byte_drop ? LINK_SYNC : LINK_RX;
          default:   link_nxt = LINK_SYNC;
        endcase
      end
    end
  end

  // frame datapath and result
  always_comb begin
    sc_nxt      = sc_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    addr_ok_nxt = addr_ok_r;
    ovf_nxt     = ovf_r;
    res_valid   = 1'b0;
    res.kind         = KIND_DATA;
    res.data_byte    = 8'd0;
    res.byte_index   = 8'd0;
    res.frame_length = 9'd0;
    res.reject_cause = CAUSE_NONE;

    if (accept) begin
      if (is_tick) begin
        if (link_r != LINK_WAIT) begin
          if (!tick_hit) begin
            sc_nxt = sc_inc;
          end else begin
            if (link_r == LINK_RX) begin
              res_valid = 1'b1;
              res.frame_length = 9'(cnt_r);
              priority if (ovf_r)             res.reject_cause = CAUSE_OVERFLOW;
              else if (cnt_r < CNT_MIN)       res.reject_cause = CAUSE_SHORT;
              else if (!addr_ok_r)            res.reject_cause = CAUSE_ADDRESS;
              else if (crc_r != 16'd0)        res.reject_cause = CAUSE_CRC;
              else                            res.reject_cause = CAUSE_NONE;
              res.kind = (res.reject_cause == CAUSE_NONE) ? KIND_ACCEPT : KIND_REJECT;
            end
            // frame state cleared on entering wait
            sc_nxt      = 8'd0;
            cnt_nxt     = '0;
            crc_nxt     = CRC_INIT;
            addr_ok_nxt = 1'b0;
            ovf_nxt     = 1'b0;
          end
        end
      end else if (link_r == LINK_SYNC) begin
        sc_nxt = 8'd0;  // restart silence wait
      end else if (byte_drop) begin
        sc_nxt      = 8'd0;
        cnt_nxt     = '0;
        crc_nxt     = CRC_INIT;
        addr_ok_nxt = 1'b0;
        ovf_nxt     = 1'b0;
      end else begin
        if (link_r == LINK_WAIT) begin
          addr_ok_nxt = (in_rx_byte == station_addr_r);
        end
        sc_nxt = 8'd0;
        if (cnt_r >= CNT_MAX) begin
          cnt_nxt = CNT_MAX;
          ovf_nxt = 1'b1;
        end else begin
          crc_nxt        = crc_upd;
          res_valid      = 1'b1;
          res.kind       = KIND_DATA;
          res.data_byte  = in_rx_byte;
          res.byte_index = 8'(cnt_r);
          cnt_nxt        = cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r    <= LINK_SYNC;
      sc_r      <= 8'd0;
      cnt_r     <= '0;
      crc_r     <= CRC_INIT;
      addr_ok_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      link_r    <= link_nxt;
      sc_r      <= sc_nxt;
      cnt_r     <= cnt_nxt;
      crc_r     <= crc_nxt;
      addr_ok_r <= addr_ok_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // output register plus skid beat
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;   // no accept while skid is full
      end else begin
        out_valid_nxt = res_valid;
        out_nxt       = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_data_byte    = out_r.data_byte;
  assign out_byte_index   = out_r.byte_index;
  assign out_frame_length = out_r.frame_length;
  assign out_reject_cause = out_r.reject_cause;

endmodule

### design/rtu_crc16.sv
// One-byte update of the reflected CRC-16 (poly 0xA001).
// Depends on rtu_pkg for the polynomial.
module rtu_crc16 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);
  import rtu_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule
